/* hdl/acsfr_pkg.sv */
// Package for the status frame receiver: payload structs, frame constants
// and the internal event struct passed from the frame tracker to the decoder.
// Depends on nothing.
package acsfr_pkg;

    localparam int unsigned WatchCount = 5;

    localparam logic [7:0] HEADER_BYTE   = 8'hAA;
    localparam logic [7:0] HIGH_NIBBLE   = 8'hF0;
    localparam logic [7:0] LOW_NIBBLE    = 8'h0F;
    localparam logic [7:0] FLAG_STANDBY  = 8'h10;
    localparam logic [7:0] FLAG_FAN_MED  = 8'hB0;
    localparam logic [7:0] FLAG_FAN_HIGH = 8'hD0;
    localparam logic [7:0] SWING_CODE    = 8'h0C;
    localparam logic [3:0] SUM_LEN       = 4'd14;
    localparam logic [3:0] LAST_INDEX    = 4'd15;

    // Mode codes.
    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_COOL = 3'd1;
    localparam logic [2:0] MODE_DRY  = 3'd2;
    localparam logic [2:0] MODE_FAN  = 3'd3;
    localparam logic [2:0] MODE_HEAT = 3'd4;

    // Action codes.
    localparam logic [2:0] ACT_OFF     = 3'd0;
    localparam logic [2:0] ACT_IDLE    = 3'd1;
    localparam logic [2:0] ACT_COOLING = 3'd2;
    localparam logic [2:0] ACT_DRYING  = 3'd3;
    localparam logic [2:0] ACT_FAN     = 3'd4;
    localparam logic [2:0] ACT_HEATING = 3'd5;

    // Fan codes.
    localparam logic [1:0] FAN_LOW  = 2'd0;
    localparam logic [1:0] FAN_MED  = 2'd1;
    localparam logic [1:0] FAN_HIGH = 2'd2;

    // Low nibble codes of frame byte 1 that select a mode.
    localparam logic [3:0] SEL_DRY  = 4'h2;
    localparam logic [3:0] SEL_FAN  = 4'h3;
    localparam logic [3:0] SEL_HEAT = 4'h4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_start;
    } in_item_t;

    typedef struct packed {
        logic       frame_status;
        logic [2:0] unit_mode;
        logic [2:0] unit_action;
        logic [1:0] fan_level;
        logic       swing_on;
        logic [7:0] set_temp;
        logic [7:0] probe_temp;
        logic       changed;
    } out_item_t;

    typedef logic [WatchCount-1:0][7:0] watch_bytes_t;

    typedef struct packed {
        logic         done;
        logic         good;
        watch_bytes_t bytes;
    } frame_event_t;

endpackage

/* hdl/acsfr_tracker.sv */
// Frame tracker: header hunt, byte capture, running checksum and burst drop.
// Depends on acsfr_pkg.
module acsfr_tracker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  acsfr_pkg::in_item_t   item,
    output acsfr_pkg::frame_event_t frame_event
);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_CAPTURE = 2'd1;
    localparam logic [1:0] PH_DROP    = 2'd2;
    // Unused code; it is treated as hunting.
    localparam logic [1:0] PH_SPARE   = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] index_reg, index_next;
    logic [7:0] sum_reg, sum_next;
    acsfr_pkg::watch_bytes_t bytes_reg, bytes_next;
    logic [1:0] phase_eff;
    logic       done;

    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        sum_next   = sum_reg;
        bytes_next = bytes_reg;
        done       = 1'b0;
        phase_eff  = (item.burst_start || phase_reg == PH_SPARE) ? PH_HUNT : phase_reg;
        if (accept)
        begin
            phase_next = phase_eff;
            unique case (phase_eff)
                PH_DROP:
                begin
                end
                PH_CAPTURE:
                begin
                    if (index_reg < acsfr_pkg::SUM_LEN)
                    begin
                        sum_next = sum_reg + item.rx_byte;
                    end
                    unique case (index_reg)
                        4'd1:    bytes_next[0] = item.rx_byte;
                        4'd2:    bytes_next[1] = item.rx_byte;
                        4'd3:    bytes_next[2] = item.rx_byte;
                        4'd7:    bytes_next[3] = item.rx_byte;
                        4'd11:   bytes_next[4] = item.rx_byte;
                        default: ;
                    endcase
                    if (index_reg == acsfr_pkg::LAST_INDEX)
                    begin
                        done       = 1'b1;
                        phase_next = PH_DROP;
                        index_next = 4'd0;
                    end
                    else
                    begin
                        index_next = index_reg + 4'd1;
                    end
                end
                default:
                begin
                    if (item.rx_byte == acsfr_pkg::HEADER_BYTE)
                    begin
                        phase_next = PH_CAPTURE;
                        index_next = 4'd0;
                        sum_next   = acsfr_pkg::HEADER_BYTE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            index_reg <= 4'd0;
            sum_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            sum_reg   <= sum_next;
        end
    end

    // Captured bytes are always written before they are read.
    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    // The checksum byte is the last frame byte itself; byte 14 is not summed.
    assign frame_event.done  = done;
    assign frame_event.good  = (sum_reg == item.rx_byte);
    assign frame_event.bytes = bytes_next;

endmodule

/* hdl/acsfr_decoder.sv */
// Frame decoder: turns a completed frame into a result and keeps the
// published copy of the watched bytes. Depends on acsfr_pkg.
module acsfr_decoder
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  acsfr_pkg::frame_event_t frame_event,
    output acsfr_pkg::out_item_t    result
);

    acsfr_pkg::watch_bytes_t pub_reg, pub_next;
    logic [7:0] flag_bits;
    logic [3:0] mode_sel;
    logic [3:0] act_bits;
    logic       chg;

    always_comb
    begin
        flag_bits = frame_event.bytes[0] & acsfr_pkg::HIGH_NIBBLE;
        mode_sel  = frame_event.bytes[0][3:0];
        act_bits  = frame_event.bytes[4][3:0];
        chg       = (frame_event.bytes != pub_reg);
        pub_next  = pub_reg;
        result    = '0;

        if (!frame_event.good)
        begin
            result.frame_status = 1'b1;
        end
        else
        begin
            if (flag_bits == acsfr_pkg::FLAG_STANDBY)
            begin
                result.unit_mode   = acsfr_pkg::MODE_OFF;
                result.unit_action = acsfr_pkg::ACT_OFF;
            end
            else
            begin
                unique case (mode_sel)
                    acsfr_pkg::SEL_DRY:
                    begin
                        result.unit_mode   = acsfr_pkg::MODE_DRY;
                        result.unit_action = acsfr_pkg::ACT_DRYING;
                    end
                    acsfr_pkg::SEL_FAN:
                    begin
                        result.unit_mode   = acsfr_pkg::MODE_FAN;
                        result.unit_action = acsfr_pkg::ACT_FAN;
                    end
                    acsfr_pkg::SEL_HEAT:
                    begin
                        result.unit_mode   = acsfr_pkg::MODE_HEAT;
                        result.unit_action = acsfr_pkg::ACT_HEATING;
                    end
                    default:
                    begin
                        result.unit_mode   = acsfr_pkg::MODE_COOL;
                        result.unit_action = acsfr_pkg::ACT_COOLING;
                    end
                endcase
                if (act_bits == 4'd0)
                begin
                    result.unit_action = acsfr_pkg::ACT_IDLE;
                end
            end

            unique if (flag_bits == acsfr_pkg::FLAG_FAN_MED)
                result.fan_level = acsfr_pkg::FAN_MED;
            else if (flag_bits == acsfr_pkg::FLAG_FAN_HIGH)
                result.fan_level = acsfr_pkg::FAN_HIGH;
            else
                result.fan_level = acsfr_pkg::FAN_LOW;

            result.swing_on = ((frame_event.bytes[1] & acsfr_pkg::LOW_NIBBLE)
                              == acsfr_pkg::SWING_CODE);
            result.set_temp   = frame_event.bytes[2];
            result.probe_temp = frame_event.bytes[3];
            result.changed    = chg;

            if (frame_event.done && chg)
            begin
                pub_next = frame_event.bytes;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pub_reg <= '0;
        end
        else
        begin
            pub_reg <= pub_next;
        end
    end

endmodule

/* hdl/acsfr_out_queue.sv */
// Two-entry result queue: a result register and a skid register behind it.
// Depends on acsfr_pkg.
module acsfr_out_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  acsfr_pkg::out_item_t push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output acsfr_pkg::out_item_t out_data
);

    logic                 head_valid_reg;
    logic                 skid_valid_reg;
    acsfr_pkg::out_item_t head_reg;
    acsfr_pkg::out_item_t skid_reg;
    logic                 head_free;

    assign head_free = !head_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (head_free)
        begin
            head_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                skid_reg <= push_data;
            end
            else
            begin
                head_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

endmodule

/* hdl/ac_status_frame_receiver_unit.sv */
// Status frame receiver for an air-conditioner controller, top level.
// A result is pushed into the result queue on the transfer of the final frame byte.
// Throughput: one byte per cycle unless in_stall; each byte is processed as it is transferred.
// The two-entry result queue lets input continue while one result waits downstream.
// Reset (rst_n, asynchronous, active low) returns to header hunting and clears the
// published copy of the watched bytes and the result queue.
module ac_status_frame_receiver_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  acsfr_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output acsfr_pkg::out_item_t out_data
);

    logic                    accept;
    logic                    queue_full;
    acsfr_pkg::frame_event_t frame_event;
    acsfr_pkg::frame_event_t gated_event;
    acsfr_pkg::out_item_t    result;

    // Input is held off only when both queue entries are taken, since the
    // incoming byte could complete a frame.
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // The tracker walks the header hunt, capture and drop phases and flags
    // the transfer that carries the checksum byte of a frame.
    acsfr_tracker u_tracker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (in_data),
        .frame_event (frame_event)
    );

    // The decoder only updates its published copy on a real completion, so
    // the done flag is qualified here with the transfer itself.
    always_comb
    begin
        gated_event      = frame_event;
        gated_event.done = frame_event.done && accept;
    end

    acsfr_decoder u_decoder
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_event (gated_event),
        .result      (result)
    );

    acsfr_out_queue u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (gated_event.done),
        .push_data (result),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* dv/ac_status_frame_receiver_unit_tb.sv */
// Self-checking testbench for the air-conditioner status frame receiver.
// A class-based scoreboard predicts each decoded status result from the byte stream.
// Depends on acsfr_pkg (hdl/acsfr_pkg.sv) and the ac_status_frame_receiver_unit top level.
module ac_status_frame_receiver_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 10;
    // Total input transfers, noise and dropped tails included.
    localparam int BYTE_TARGET = 1150;
    // Watchdog limit for the whole run.
    localparam int CYCLE_LIMIT = 200000;
    // Short drain after the last outstanding result has been taken.
    localparam int DRAIN_CYCLES = 8;

    // Receiver state, kept in the scoreboard's own copy of the block's behaviour.
    typedef enum logic [1:0] {RX_HUNT, RX_CAPTURE, RX_DROP} rx_phase_t;

    // Frame bytes 0..15 as they follow the header; byte 15 is replaced by the checksum.
    typedef logic [7:0] frame_bytes_t [16];

    // The scoreboard tracks the receiver state byte by byte and queues the status
    // result that each completed frame should produce.
    class status_frame_checker;
        rx_phase_t  phase;
        logic [3:0] index;
        logic [7:0] sum;
        logic [7:0] captured  [acsfr_pkg::WatchCount];
        logic [7:0] published [acsfr_pkg::WatchCount];
        acsfr_pkg::out_item_t pending_status [$];
        int errors;
        int frame_bytes;
        int good_frames;
        int bad_frames;
        int change_count;
        int compared;

        function new();
            phase = RX_HUNT;
            index = '0;
            sum   = '0;
            foreach (captured[i]) captured[i] = '0;
            foreach (published[i]) published[i] = '0;
            errors = 0;
            frame_bytes = 0;
            good_frames = 0;
            bad_frames = 0;
            change_count = 0;
            compared = 0;
        endfunction

        // Advances the predicted state by one transferred byte.
        function void note_byte(acsfr_pkg::in_item_t item);
            acsfr_pkg::out_item_t status;
            logic [7:0] b;
            logic [7:0] flags;
            bit differs;
            b = item.rx_byte;
            differs = 1'b0;
            status = '0;
            flags = '0;

            // A new burst always abandons whatever was in progress.
            if (item.burst_start)
                phase = RX_HUNT;

            case (phase)
                RX_HUNT:
                begin
                    if (b == acsfr_pkg::HEADER_BYTE)
                    begin
                        phase = RX_CAPTURE;
                        index = '0;
                        sum   = acsfr_pkg::HEADER_BYTE;
                        frame_bytes++;
                    end
                end
                RX_CAPTURE:
                begin
                    frame_bytes++;
                    if (index < acsfr_pkg::SUM_LEN)
                        sum = sum + b;
                    case (index)
                        4'd1:  captured[0] = b;
                        4'd2:  captured[1] = b;
                        4'd3:  captured[2] = b;
                        4'd7:  captured[3] = b;
                        4'd11: captured[4] = b;
                        default: ;
                    endcase
                    if (index == acsfr_pkg::LAST_INDEX)
                    begin
                        if (sum != b)
                        begin
                            // A bad checksum reports only the status bit.
                            status.frame_status = 1'b1;
                            bad_frames++;
                        end
                        else
                        begin
                            good_frames++;
                            flags = captured[0] & acsfr_pkg::HIGH_NIBBLE;
                            if (flags == acsfr_pkg::FLAG_STANDBY)
                            begin
                                status.unit_mode   = acsfr_pkg::MODE_OFF;
                                status.unit_action = acsfr_pkg::ACT_OFF;
                            end
                            else
                            begin
                                case (captured[0][3:0])
                                    acsfr_pkg::SEL_DRY:
                                    begin
                                        status.unit_mode   = acsfr_pkg::MODE_DRY;
                                        status.unit_action = acsfr_pkg::ACT_DRYING;
                                    end
                                    acsfr_pkg::SEL_FAN:
                                    begin
                                        status.unit_mode   = acsfr_pkg::MODE_FAN;
                                        status.unit_action = acsfr_pkg::ACT_FAN;
                                    end
                                    acsfr_pkg::SEL_HEAT:
                                    begin
                                        status.unit_mode   = acsfr_pkg::MODE_HEAT;
                                        status.unit_action = acsfr_pkg::ACT_HEATING;
                                    end
                                    default:
                                    begin
                                        status.unit_mode   = acsfr_pkg::MODE_COOL;
                                        status.unit_action = acsfr_pkg::ACT_COOLING;
                                    end
                                endcase
                                if ((captured[4] & acsfr_pkg::LOW_NIBBLE) == 8'h00)
                                    status.unit_action = acsfr_pkg::ACT_IDLE;
                            end
                            case (flags)
                                acsfr_pkg::FLAG_FAN_MED:
                                    status.fan_level = acsfr_pkg::FAN_MED;
                                acsfr_pkg::FLAG_FAN_HIGH:
                                    status.fan_level = acsfr_pkg::FAN_HIGH;
                                default:
                                    status.fan_level = acsfr_pkg::FAN_LOW;
                            endcase
                            status.swing_on   = ((captured[1] & acsfr_pkg::LOW_NIBBLE)
                                                 == acsfr_pkg::SWING_CODE);
                            status.set_temp   = captured[2];
                            status.probe_temp = captured[3];
                            foreach (captured[i])
                                if (captured[i] != published[i])
                                    differs = 1'b1;
                            if (differs)
                            begin
                                published = captured;
                                change_count++;
                            end
                            status.changed = differs;
                        end
                        pending_status.push_back(status);
                        phase = RX_DROP;
                        index = '0;
                    end
                    else
                        index = index + 4'd1;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compares a transferred result with the oldest outstanding prediction.
        function void check_status(acsfr_pkg::out_item_t got);
            acsfr_pkg::out_item_t want;
            if (pending_status.size() == 0)
            begin
                $error("result with nothing outstanding: %h", got);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            compared++;
            compare_field("frame_status", want.frame_status, got.frame_status);
            compare_field("unit_mode",    want.unit_mode,    got.unit_mode);
            compare_field("unit_action",  want.unit_action,  got.unit_action);
            compare_field("fan_level",    want.fan_level,    got.fan_level);
            compare_field("swing_on",     want.swing_on,     got.swing_on);
            compare_field("set_temp",     want.set_temp,     got.set_temp);
            compare_field("probe_temp",   want.probe_temp,   got.probe_temp);
            compare_field("changed",      want.changed,      got.changed);
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    acsfr_pkg::in_item_t  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    acsfr_pkg::out_item_t out_data;

    status_frame_checker sb;

    int cycle_count = 0;
    // Every input transfer, whatever phase it lands in.
    int items_sent = 0;
    // Sender burst bookkeeping: transfers left before the next possible gap.
    int run_left = 0;
    // Receiver stall pattern: current style and how long it lasts.
    int stall_style = 0;
    int stall_left = 0;

    ac_status_frame_receiver_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // The receiver switches between several stall styles, each held for a
    // random stretch, so that back-pressure falls on every phase of a frame.
    // One style never stalls at all.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(10, 250);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left % 4 == 0);
        endcase
    end

    // Every result transfer is checked against the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_status(out_data);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** ac_status_frame_receiver_unit: FAILED **");
            $finish;
        end
    end

    // Offers one byte and holds it until the receiver takes it. Now and then
    // the sender drops valid for a random gap between bursts of transfers.
    task automatic send_byte(input logic [7:0] b, input logic new_burst);
        acsfr_pkg::in_item_t item;
        int gap;
        item.rx_byte     = b;
        item.burst_start = new_burst;
        if (run_left == 0)
        begin
            run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        run_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        sb.note_byte(item);
    endtask

    // Holds the sender off until every outstanding status result has been taken.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_status.size() != 0)
            @(posedge clk);
    endtask

    // Sends a header and then the first count frame bytes. When the whole frame
    // goes out, the final byte carries the checksum, deliberately spoilt if asked.
    task automatic send_frame(input frame_bytes_t fb, input int count, input bit corrupt,
                              input logic new_burst);
        logic [7:0] sum;
        sum = acsfr_pkg::HEADER_BYTE;
        send_byte(acsfr_pkg::HEADER_BYTE, new_burst);
        for (int i = 0; i < count; i++)
        begin
            if (i < 14)
                sum = sum + fb[i];
            if (i == 15)
                send_byte(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum, 1'b0);
            else
                send_byte(fb[i], 1'b0);
        end
    endtask

    // Random frame contents, biased towards the standby and fan flags, the mode
    // selectors, the swing code and an idle action. Sometimes the watched bytes
    // repeat the last published copy so that a frame without a change is seen.
    function automatic frame_bytes_t random_frame();
        frame_bytes_t fb;
        logic [3:0] hi;
        logic [3:0] lo;
        foreach (fb[i]) fb[i] = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0:       hi = acsfr_pkg::FLAG_STANDBY[7:4];
            1:       hi = acsfr_pkg::FLAG_FAN_MED[7:4];
            2:       hi = acsfr_pkg::FLAG_FAN_HIGH[7:4];
            default: hi = 4'($urandom_range(0, 15));
        endcase
        case ($urandom_range(0, 4))
            0:       lo = acsfr_pkg::SEL_DRY;
            1:       lo = acsfr_pkg::SEL_FAN;
            2:       lo = acsfr_pkg::SEL_HEAT;
            default: lo = 4'($urandom_range(0, 15));
        endcase
        fb[1] = {hi, lo};
        if ($urandom_range(0, 2) == 0)
            fb[2][3:0] = acsfr_pkg::SWING_CODE[3:0];
        if ($urandom_range(0, 2) == 0)
            fb[11][3:0] = 4'h0;
        if ($urandom_range(0, 3) == 0)
        begin
            fb[1]  = sb.published[0];
            fb[2]  = sb.published[1];
            fb[3]  = sb.published[2];
            fb[7]  = sb.published[3];
            fb[11] = sb.published[4];
        end
        // A header value inside the frame must be captured as ordinary data.
        if ($urandom_range(0, 5) == 0)
            fb[$urandom_range(0, 14)] = acsfr_pkg::HEADER_BYTE;
        return fb;
    endfunction

    initial
    begin
        frame_bytes_t fb;
        int frame_no;
        int count;
        int noise_len;
        bit corrupt;
        bit lead_noise;
        logic [7:0] b;

        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening. Noise at both byte extremes is ignored while hunting,
        // then a good standby frame with the swing code, a header value in its
        // body and extreme temperatures. A stray byte after it is dropped, a new
        // burst that opens with a header starts a frame at once, and a further
        // new burst abandons that partial frame.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        fb = '{8'h00, 8'h14, 8'hFC, 8'hFF, 8'hAA, 8'h11, 8'h22, 8'h00,
               8'h33, 8'h44, 8'h55, 8'h80, 8'h66, 8'h77, 8'hFF, 8'h00};
        send_frame(fb, 16, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0);
        wait_for_results();
        send_frame(fb, 3, 1'b0, 1'b1);
        send_byte(8'h3C, 1'b1);

        // Random part: mostly well-formed bursts with random contents, some with
        // a spoilt checksum, some cut short by the next burst, and noise before
        // and after the frames.
        frame_no = 0;
        while (items_sent < BYTE_TARGET)
        begin
            lead_noise = $urandom_range(0, 1);
            if (lead_noise)
            begin
                noise_len = $urandom_range(1, 3);
                for (int k = 0; k < noise_len; k++)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == acsfr_pkg::HEADER_BYTE)
                        b = ~b;
                    send_byte(b, k == 0);
                end
            end
            count   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 16;
            corrupt = ($urandom_range(0, 5) == 0);
            send_frame(random_frame(), count, corrupt, !lead_noise);
            // Bytes after a completed frame belong to the dropped tail of the burst.
            if (count == 16)
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            if (frame_no % 12 == 11)
                wait_for_results();
            frame_no++;
        end

        in_valid <= 1'b0;
        while (sb.pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes, %0d of them header and frame bytes: %0d good frames, %0d bad.",
                 items_sent, sb.frame_bytes, sb.good_frames, sb.bad_frames);
        $display("%0d status results compared, %0d of them reporting a change.",
                 sb.compared, sb.change_count);
        if (sb.errors == 0)
            $display("** ac_status_frame_receiver_unit: PASSED **");
        else
            $display("** ac_status_frame_receiver_unit: FAILED **");
        $finish;
    end

endmodule

/* ac_status_frame_receiver_unit.f */
hdl/acsfr_pkg.sv
hdl/acsfr_tracker.sv
hdl/acsfr_decoder.sv
hdl/acsfr_out_queue.sv
hdl/ac_status_frame_receiver_unit.sv
dv/ac_status_frame_receiver_unit_tb.sv
